@@ design/stl_pkg.sv @@
// Shared types and constants of the source text lexer.
package stl_pkg;

  // Text capacity in bytes; offsets past the last usable one saturate.
  localparam int unsigned TEXT_BYTES = 65536;
  localparam logic [16:0] LAST_OFFSET =
    17'(((TEXT_BYTES - 1) > 65535) ? 65535 : (TEXT_BYTES - 1));

  // Arabic comma, encoded as two UTF-8 bytes.
  localparam logic [7:0] ARABIC_COMMA_LEAD  = 8'hD8;
  localparam logic [7:0] ARABIC_COMMA_TRAIL = 8'h8C;

  // Depth of the queue between the lexer and the output stage.
  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic [2:0] {
    KIND_COMMENT = 3'd0,
    KIND_STRING  = 3'd1,
    KIND_NUMBER  = 3'd2,
    KIND_IDENT   = 3'd3,
    KIND_BRACKET = 3'd4,
    KIND_OPER    = 3'd5,
    KIND_COMMA   = 3'd6
  } kind_e;

  typedef struct packed {
    logic [15:0] start;
    logic [16:0] length;
    kind_e       kind;
  } rec_t;

  // All records caused by one byte; rec1 only counts when two is set.
  typedef struct packed {
    logic two;
    logic overflow;
    rec_t rec0;
    rec_t rec1;
  } bundle_t;

  // Token spanning first..last; an inverted span collapses to one byte.
  function automatic rec_t make_rec(logic [15:0] first, logic [15:0] last, kind_e kind);
    rec_t        r;
    logic [15:0] stop;
    stop     = (last < first) ? first : last;
    r.start  = first;
    r.length = {1'b0, stop} - {1'b0, first} + 17'd1;
    r.kind   = kind;
    return r;
  endfunction

endpackage

@@ design/stl_front.sv @@
// Lexer front end: byte classifier and token state machine.
module stl_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              beat_i,
  input  logic [7:0]        text_byte_i,
  input  logic              end_of_text_i,
  output logic              q_push_o,
  output stl_pkg::bundle_t  q_data_o
);

  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_HASH  = 4'd1,
    M_LINE  = 4'd2,
    M_BLOCK = 4'd3,
    M_STR   = 4'd4,
    M_NUM   = 4'd5,
    M_IDENT = 4'd6,
    M_D8    = 4'd7,
    M_OP    = 4'd8
  } mode_e;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic [1:0] lead_skip(logic [7:0] c);
    if (c[7:5] == 3'b110) return 2'd1;
    if (c[7:4] == 4'b1110) return 2'd2;
    return 2'd0;
  endfunction

  function automatic logic pairable(logic [7:0] c);
    return (c == "=") || (c == "!") || (c == "<") || (c == ">") || (c == "&") ||
           (c == "|") || (c == "*") || (c == "+") || (c == "-") || (c == "/");
  endfunction

  function automatic logic forms_pair(logic [7:0] a, logic [7:0] b);
    if (b == "=") begin
      return (a == "=") || (a == "!") || (a == "<") || (a == ">") ||
             (a == "+") || (a == "-") || (a == "*") || (a == "/");
    end
    return ((a == "&") && (b == "&")) || ((a == "|") && (b == "|")) ||
           ((a == "*") && (b == "*"));
  endfunction

  function automatic stl_pkg::kind_e mode_kind(mode_e m);
    case (m)
      M_STR:         return stl_pkg::KIND_STRING;
      M_NUM:         return stl_pkg::KIND_NUMBER;
      M_IDENT, M_D8: return stl_pkg::KIND_IDENT;
      M_OP:          return stl_pkg::KIND_OPER;
      default:       return stl_pkg::KIND_COMMENT;
    endcase
  endfunction

  mode_e       mode_q, mode_d;
  logic [15:0] start_q, start_d;
  logic [16:0] pos_q, pos_d;
  logic [7:0]  op_q, op_d;
  logic [1:0]  skip_q, skip_d;
  logic        esc_q, esc_d;
  logic        star_q, star_d;
  logic        quote_q, quote_d;
  logic        ovf_q, ovf_d;

  logic          sat;
  logic [15:0]   p, prev;
  logic          do_begin;
  logic          a_v, b_v, c_v;
  stl_pkg::rec_t a_r, b_r, c_r;
  logic [7:0]    c;

  assign c   = text_byte_i;
  assign sat = pos_q > stl_pkg::LAST_OFFSET;
  assign p   = sat ? stl_pkg::LAST_OFFSET[15:0] : pos_q[15:0];
  assign prev = sat ? stl_pkg::LAST_OFFSET[15:0] :
                ((p != 16'd0) ? (p - 16'd1) : 16'd0);

  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    op_d     = op_q;
    skip_d   = skip_q;
    esc_d    = esc_q;
    star_d   = star_q;
    quote_d  = quote_q;
    ovf_d    = ovf_q | sat;
    pos_d    = pos_q;
    do_begin = 1'b0;
    a_v = 1'b0;
    b_v = 1'b0;
    c_v = 1'b0;
    a_r = stl_pkg::make_rec(start_q, prev, stl_pkg::KIND_COMMENT);
    b_r = stl_pkg::make_rec(p, p, stl_pkg::KIND_OPER);

    unique case (mode_q)
      M_HASH: begin
        if (c == "*") begin
          mode_d = M_BLOCK;
          star_d = 1'b0;
        end else if (c == "\n") begin
          a_v    = 1'b1;
          mode_d = M_IDLE;
        end else begin
          mode_d = M_LINE;
        end
      end
      M_LINE: begin
        if (c == "\n") begin
          a_v    = 1'b1;
          mode_d = M_IDLE;
        end
      end
      M_BLOCK: begin
        if (star_q && (c == "#")) begin
          a_v    = 1'b1;
          a_r    = stl_pkg::make_rec(start_q, p, stl_pkg::KIND_COMMENT);
          mode_d = M_IDLE;
          star_d = 1'b0;
        end else begin
          star_d = (c == "*");
        end
      end
      M_STR: begin
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (c == "\\") begin
          esc_d = 1'b1;
        end else if (c == (quote_q ? 8'("'") : 8'("\""))) begin
          a_v    = 1'b1;
          a_r    = stl_pkg::make_rec(start_q, p, stl_pkg::KIND_STRING);
          mode_d = M_IDLE;
        end
      end
      M_NUM: begin
        if (!(is_digit(c) || (c == ".") || (c == "_"))) begin
          a_v      = 1'b1;
          a_r      = stl_pkg::make_rec(start_q, prev, stl_pkg::KIND_NUMBER);
          do_begin = 1'b1;
        end
      end
      M_IDENT: begin
        if (skip_q != 2'd0) begin
          skip_d = skip_q - 2'd1;
        end else if (is_alpha(c) || is_digit(c) || (lead_skip(c) != 2'd0) ||
                     (c[7:6] == 2'b10)) begin
          skip_d = lead_skip(c);
        end else begin
          a_v      = 1'b1;
          a_r      = stl_pkg::make_rec(start_q, prev, stl_pkg::KIND_IDENT);
          do_begin = 1'b1;
        end
      end
      M_D8: begin
        if (c == stl_pkg::ARABIC_COMMA_TRAIL) begin
          a_v    = 1'b1;
          a_r    = stl_pkg::make_rec(start_q, p, stl_pkg::KIND_COMMA);
          mode_d = M_IDLE;
        end else begin
          mode_d = M_IDENT;
          skip_d = 2'd0;
        end
      end
      M_OP: begin
        a_v = 1'b1;
        if (forms_pair(op_q, c)) begin
          a_r    = stl_pkg::make_rec(start_q, p, stl_pkg::KIND_OPER);
          mode_d = M_IDLE;
        end else begin
          a_r      = stl_pkg::make_rec(start_q, prev, stl_pkg::KIND_OPER);
          do_begin = 1'b1;
        end
      end
      default: do_begin = 1'b1;
    endcase

    // Start of a new token at this byte.
    if (do_begin) begin
      mode_d  = M_IDLE;
      start_d = p;
      if ((c == " ") || (c == "\t") || (c == 8'h0D) || (c == "\n")) begin
        mode_d = M_IDLE;
      end else if (c == "#") begin
        mode_d = M_HASH;
      end else if ((c == "\"") || (c == "'")) begin
        mode_d  = M_STR;
        quote_d = (c == "'");
        esc_d   = 1'b0;
      end else if (is_digit(c)) begin
        mode_d = M_NUM;
      end else if (c == stl_pkg::ARABIC_COMMA_LEAD) begin
        mode_d = M_D8;
      end else if (is_alpha(c) || (lead_skip(c) != 2'd0)) begin
        mode_d = M_IDENT;
        skip_d = lead_skip(c);
      end else if ((c == "(") || (c == ")") || (c == "[") || (c == "]")) begin
        b_v = 1'b1;
        b_r = stl_pkg::make_rec(p, p, stl_pkg::KIND_BRACKET);
      end else if (c == ",") begin
        b_v = 1'b1;
        b_r = stl_pkg::make_rec(p, p, stl_pkg::KIND_COMMA);
      end else if (pairable(c)) begin
        mode_d = M_OP;
        op_d   = c;
      end else if ((c == "%") || (c == "^") || (c == "~") || (c == "?") || (c == ":")) begin
        b_v = 1'b1;
      end
    end

    // End of text closes whatever is still open.
    c_v = end_of_text_i && (mode_d != M_IDLE);
    c_r = stl_pkg::make_rec(start_d, p, mode_kind(mode_d));

    q_data_o.overflow = ovf_d;
    q_data_o.two      = 1'b0;
    q_data_o.rec0     = c_r;
    q_data_o.rec1     = c_r;
    if (a_v) begin
      q_data_o.rec0 = a_r;
      q_data_o.two  = b_v || c_v;
      q_data_o.rec1 = b_v ? b_r : c_r;
    end else if (b_v) begin
      q_data_o.rec0 = b_r;
      q_data_o.two  = c_v;
    end
    q_push_o = beat_i && (a_v || b_v || c_v);

    if (end_of_text_i) begin
      mode_d  = M_IDLE;
      start_d = 16'd0;
      pos_d   = 17'd0;
      op_d    = 8'd0;
      skip_d  = 2'd0;
      esc_d   = 1'b0;
      star_d  = 1'b0;
      quote_d = 1'b0;
      ovf_d   = 1'b0;
    end else if (!sat) begin
      pos_d = pos_q + 17'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      start_q <= 16'd0;
      pos_q   <= 17'd0;
      op_q    <= 8'd0;
      skip_q  <= 2'd0;
      esc_q   <= 1'b0;
      star_q  <= 1'b0;
      quote_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (beat_i) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      op_q    <= op_d;
      skip_q  <= skip_d;
      esc_q   <= esc_d;
      star_q  <= star_d;
      quote_q <= quote_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

@@ design/stl_fifo.sv @@
// Short queue of per-byte token bundles between lexer and output stage.
module stl_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  stl_pkg::bundle_t  wdata_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              pop_i,
  output stl_pkg::bundle_t  rdata_o
);

  localparam int unsigned PtrW = $clog2(stl_pkg::FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(stl_pkg::FIFO_DEPTH + 1);

  stl_pkg::bundle_t mem_q [stl_pkg::FIFO_DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CntW'(stl_pkg::FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(stl_pkg::FIFO_DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(stl_pkg::FIFO_DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

@@ design/stl_back.sv @@
// Output stage: unpacks bundles into single token beats.
module stl_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  stl_pkg::bundle_t  q_data_i,
  output logic              q_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output stl_pkg::rec_t     rec_o,
  output logic              run_last_o,
  output logic              overflow_o
);

  stl_pkg::bundle_t bun_q;
  logic             valid_q;
  logic             idx_q;
  logic             take, take_last;

  assign empty_o    = !valid_q;
  assign rec_o      = idx_q ? bun_q.rec1 : bun_q.rec0;
  assign run_last_o = idx_q || !bun_q.two;
  assign overflow_o = bun_q.overflow;
  assign take       = pop_i && valid_q;
  assign take_last  = take && run_last_o;
  assign q_pop_o    = q_valid_i && (!valid_q || take_last);

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      bun_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
      idx_q   <= 1'b0;
    end else if (take_last) begin
      valid_q <= 1'b0;
      idx_q   <= 1'b0;
    end else if (take) begin
      idx_q <= 1'b1;
    end
  end

endmodule

@@ design/source_text_lexer_unit.sv @@
// Top level of the streaming source text lexer.
//
//   channel   handshake               payload
//   -------   ---------------------   ---------------------------------------------
//   input     push / full             text_byte_i, end_of_text_i
//   result    empty / pop             token_start_o, token_length_o, token_kind_o,
//                                     run_last_o, overflow_o
//
// One text byte is taken per cycle while full is low; the lexer state machine
// closes all tokens caused by a byte in that same cycle and queues them.
// The queue takes the bundle at the accepting edge, and the output register
// takes it from there; the token beats show from the output register, and
// a byte that causes two tokens needs two pops.
// The four-entry queue lets the lexer keep going while results wait; full
// rises only when the queue is full.
// Reset puts the lexer idle at offset 0 and empties queue and output register.
module source_text_lexer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] token_start_o,
  output logic [16:0] token_length_o,
  output logic [2:0]  token_kind_o,
  output logic        run_last_o,
  output logic        overflow_o
);

  logic             beat;      // input byte accepted this cycle
  logic             q_push, q_full, q_valid, q_pop;
  stl_pkg::bundle_t q_wdata, q_rdata;
  stl_pkg::rec_t    rec;

  assign full = q_full;
  assign beat = push && !q_full;

  // Lexer: classifies the byte and builds the bundle of closed tokens.
  stl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .beat_i        (beat),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  // Decoupling queue; bytes that close no token put nothing in it.
  stl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .rdata_o (q_rdata)
  );

  // Output register, one token per beat.
  stl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .rec_o      (rec),
    .run_last_o (run_last_o),
    .overflow_o (overflow_o)
  );

  assign token_start_o  = rec.start;
  assign token_length_o = rec.length;
  assign token_kind_o   = rec.kind;

  // The lexer only writes the queue on an accepted byte, never when full.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> (beat && !q_full))
    else $error("lexer wrote a full token queue");

  // The first token of a two-token byte is always followed by the second.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !run_last_o) |=> !empty)
    else $error("second token of a byte was lost");

  // Every delivered token covers at least one byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !empty |-> (token_length_o != 17'd0))
    else $error("zero-length token delivered");

endmodule
